### rtl/rle_pkg.sv
// ----------------------------------------------------------------------------
// rle_pkg: shared definitions for the RGB LED effect engine
// Strip size, opcodes, modes, request structs and the divide-by-255 helper.
// ----------------------------------------------------------------------------
package rle_pkg;

  // strip size and pixel index width
  localparam int LedCount = 3;
  localparam int IdxW     = 3;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(LedCount - 1);

  // event opcodes
  localparam logic [2:0] OP_TICK  = 3'd0;
  localparam logic [2:0] OP_MODE  = 3'd1;
  localparam logic [2:0] OP_SOLID = 3'd2;
  localparam logic [2:0] OP_OFF   = 3'd3;
  localparam logic [2:0] OP_KEY   = 3'd4;
  localparam logic [2:0] OP_REC   = 3'd5;

  // display modes
  localparam logic [2:0] MODE_OFF    = 3'd0;
  localparam logic [2:0] MODE_SOLID  = 3'd1;
  localparam logic [2:0] MODE_BREATH = 3'd2;
  localparam logic [2:0] MODE_FLOW   = 3'd3;
  localparam logic [2:0] MODE_BLINK  = 3'd4;

  // configuration register indexes
  localparam logic [7:0] REG_FIRST_ON = 8'd0;
  localparam logic [7:0] REG_DARK     = 8'd1;
  localparam logic [7:0] REG_TOTAL    = 8'd2;
  localparam logic [7:0] REG_MIN_STEP = 8'd3;

  // recording pulse color (orange)
  localparam logic [23:0] RecRgb = 24'h1E0F00;

  // ceil(2^17 / 3): x / 3 == (x * Div3Mult) >> 17 for any 16-bit x
  localparam logic [16:0] Div3Mult = 17'd43691;

  typedef enum logic {
    ALU_SUB,
    ALU_MUL
  } alu_op_e;

  // one operation for the shared unit
  typedef struct packed {
    alu_op_e     op;
    logic [31:0] a;
    logic [31:0] b;
  } alu_req_t;

  // one repaint request for the pixel sequencer
  typedef struct packed {
    logic            valid;
    logic [23:0]     rgb;
    logic            lit_all;
    logic [IdxW-1:0] lit_idx;
  } paint_req_t;

  // x / 255 for x below 65280
  function automatic logic [7:0] div255(input logic [15:0] x);
    logic [16:0] s;
    s = {1'b0, x} + 17'(x[15:8]) + 17'd1;
    return s[15:8];
  endfunction

endpackage

### rtl/rle_alu.sv
// ----------------------------------------------------------------------------
// rle_alu: shared arithmetic unit
// Wrapping 32-bit subtract with borrow, or 16 x 17 multiply; result registered.
// ----------------------------------------------------------------------------
module rle_alu (
  input  logic              clk_i,
  input  rle_pkg::alu_req_t req_i,
  output logic [32:0]       res_o
);
  import rle_pkg::*;

  logic [32:0] prod;
  logic [32:0] diff;
  logic [32:0] res_q;

  assign prod = {17'b0, req_i.a[15:0]} * {16'b0, req_i.b[16:0]};
  // bit 32 is the borrow: set when a < b
  assign diff = {1'b0, req_i.a} - {1'b0, req_i.b};

  always_ff @(posedge clk_i) begin
    res_q <= (req_i.op == ALU_MUL) ? prod : diff;
  end

  assign res_o = res_q;

endmodule

### rtl/rle_painter.sv
// ----------------------------------------------------------------------------
// rle_painter: pixel sequencer
// Emits one item per pixel of a repaint, pixel 0 first, last one marked.
// ----------------------------------------------------------------------------
module rle_painter (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  rle_pkg::paint_req_t       req_i,
  output logic                      busy_o,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [rle_pkg::IdxW-1:0]  pixel_index_o,
  output logic [7:0]                red_out_o,
  output logic [7:0]                green_out_o,
  output logic [7:0]                blue_out_o,
  output logic                      frame_last_o
);
  import rle_pkg::*;

  logic            busy_q, busy_d;
  logic [IdxW-1:0] cnt_q, cnt_d;
  logic [23:0]     rgb_q, rgb_d;
  logic            all_q, all_d;
  logic [IdxW-1:0] idx_q, idx_d;
  logic            lit;

  // next frame / pixel advance
  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    rgb_d  = rgb_q;
    all_d  = all_q;
    idx_d  = idx_q;
    if (busy_q) begin
      if (out_ready_i) begin
        if (cnt_q == LastIdx) begin
          busy_d = 1'b0;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
    end else if (req_i.valid) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rgb_d  = req_i.rgb;
      all_d  = req_i.lit_all;
      idx_d  = req_i.lit_idx;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rgb_q <= rgb_d;
    all_q <= all_d;
    idx_q <= idx_d;
  end

  // output item
  assign lit           = all_q || (cnt_q == idx_q);
  assign busy_o        = busy_q;
  assign out_valid_o   = busy_q;
  assign pixel_index_o = cnt_q;
  assign red_out_o     = lit ? rgb_q[23:16] : 8'd0;
  assign green_out_o   = lit ? rgb_q[15:8]  : 8'd0;
  assign blue_out_o    = lit ? rgb_q[7:0]   : 8'd0;
  assign frame_last_o  = (cnt_q == LastIdx);

endmodule

### rtl/rle_ctl.sv
// ----------------------------------------------------------------------------
// rle_ctl: effect sequencer
// Holds the effect state and config registers, steps the shared unit through
// interval compares and gamma scaling, and issues repaint requests.
// ----------------------------------------------------------------------------
module rle_ctl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [2:0]           opcode_i,
  input  logic [31:0]          now_ms_i,
  input  logic [2:0]           mode_in_i,
  input  logic [7:0]           red_in_i,
  input  logic [7:0]           green_in_i,
  input  logic [7:0]           blue_in_i,
  input  logic [15:0]          speed_ms_i,
  input  logic                 cfg_valid_i,
  input  logic [7:0]           cfg_index_i,
  input  logic [15:0]          cfg_data_i,
  output rle_pkg::alu_req_t    alu_req_o,
  input  logic [32:0]          alu_res_i,
  output rle_pkg::paint_req_t  paint_req_o,
  input  logic                 paint_busy_i
);
  import rle_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_TICK, S_THR, S_DT, S_CMP, S_GAM, S_SR, S_SG, S_SB,
    S_EL, S_P0, S_P1, S_P2
  } state_e;

  state_e          state_q, state_d;
  logic [15:0]     first_q, first_d, dark_q, dark_d, total_q, total_d;
  logic [7:0]      min_step_q, min_step_d;
  logic [2:0]      mode_q, mode_d, saved_mode_q, saved_mode_d;
  logic [23:0]     color_q, color_d, saved_color_q, saved_color_d;
  logic [15:0]     speed_q, speed_d, saved_speed_q, saved_speed_d;
  logic [31:0]     last_q, last_d, pstart_q, pstart_d;
  logic [IdxW-1:0] phase_q, phase_d;
  logic [7:0]      level_q, level_d;
  logic            rising_q, rising_d, pulse_q, pulse_d;
  logic [23:0]     prgb_q, prgb_d;
  // per-item working registers
  logic [31:0]     now_q, now_d, el_q, el_d;
  logic [15:0]     thr_q, thr_d;
  logic [7:0]      gam_q, gam_d, sr_q, sr_d, sg_q, sg_d;

  logic [23:0]     in_rgb;
  logic [7:0]      breath_step;
  logic [31:0]     step_thr;
  logic [7:0]      lvl_up;
  logic [7:0]      lvl_next;
  logic            rise_next;
  logic [IdxW:0]   ph_inc;
  logic [IdxW-1:0] ph_flow;
  logic            accept;

  assign in_rgb     = {red_in_i, green_in_i, blue_in_i};
  assign in_ready_o = (state_q == S_IDLE) && !paint_busy_i;
  assign accept     = in_valid_i && in_ready_o;

  // breathing interval: max(speed / 512, minimum)
  assign breath_step = (8'(speed_q[15:9]) < min_step_q) ? min_step_q : 8'(speed_q[15:9]);

  // interval threshold for the current mode
  always_comb begin
    case (mode_q)
      MODE_BREATH: step_thr = 32'(breath_step);
      MODE_FLOW:   step_thr = 32'(thr_q);
      default:     step_thr = 32'(speed_q[15:1]);
    endcase
  end

  // breathing level step
  assign lvl_up = level_q + 8'd2;
  always_comb begin
    lvl_next  = level_q;
    rise_next = rising_q;
    if (rising_q) begin
      if (lvl_up[7:0] >= 8'd254) begin
        lvl_next  = 8'd255;
        rise_next = 1'b0;
      end else begin
        lvl_next = lvl_up[7:0];
      end
    end else if (level_q <= 8'd2) begin
      lvl_next  = 8'd0;
      rise_next = 1'b1;
    end else begin
      lvl_next = level_q - 8'd2;
    end
  end

  // flow phase advance modulo strip length
  assign ph_inc = {1'b0, phase_q} + 1'b1;
  always_comb begin
    if (LedCount == 1) begin
      ph_flow = '0;
    end else if (ph_inc >= (IdxW + 1)'(LedCount)) begin
      ph_flow = IdxW'(ph_inc - (IdxW + 1)'(LedCount));
    end else begin
      ph_flow = ph_inc[IdxW-1:0];
    end
  end

  // sequencer
  always_comb begin
    state_d       = state_q;
    first_d       = first_q;
    dark_d        = dark_q;
    total_d       = total_q;
    min_step_d    = min_step_q;
    mode_d        = mode_q;
    color_d       = color_q;
    speed_d       = speed_q;
    saved_mode_d  = saved_mode_q;
    saved_color_d = saved_color_q;
    saved_speed_d = saved_speed_q;
    last_d        = last_q;
    pstart_d      = pstart_q;
    phase_d       = phase_q;
    level_d       = level_q;
    rising_d      = rising_q;
    pulse_d       = pulse_q;
    prgb_d        = prgb_q;
    now_d         = now_q;
    el_d          = el_q;
    thr_d         = thr_q;
    gam_d         = gam_q;
    sr_d          = sr_q;
    sg_d          = sg_q;
    alu_req_o     = '{op: ALU_SUB, a: 32'd0, b: 32'd0};
    paint_req_o   = '{valid: 1'b0, rgb: 24'd0, lit_all: 1'b1, lit_idx: '0};

    // config writes
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_FIRST_ON: first_d    = cfg_data_i;
        REG_DARK:     dark_d     = cfg_data_i;
        REG_TOTAL:    total_d    = cfg_data_i;
        REG_MIN_STEP: min_step_d = cfg_data_i[7:0];
        default: ;
      endcase
    end

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          now_d = now_ms_i;
          unique case (opcode_i)
            OP_TICK: state_d = S_TICK;
            OP_MODE: begin
              mode_d   = mode_in_i;
              color_d  = in_rgb;
              speed_d  = speed_ms_i;
              phase_d  = '0;
              level_d  = 8'd0;
              rising_d = 1'b1;
              last_d   = now_ms_i;
              pulse_d  = 1'b0;
              if (mode_in_i == MODE_OFF) begin
                paint_req_o.valid = 1'b1;
              end else if (mode_in_i == MODE_SOLID) begin
                paint_req_o.valid = 1'b1;
                paint_req_o.rgb   = in_rgb;
              end
            end
            OP_SOLID: begin
              mode_d            = MODE_SOLID;
              color_d           = in_rgb;
              pulse_d           = 1'b0;
              paint_req_o.valid = 1'b1;
              paint_req_o.rgb   = in_rgb;
            end
            OP_OFF: begin
              mode_d            = MODE_OFF;
              pulse_d           = 1'b0;
              paint_req_o.valid = 1'b1;
            end
            OP_KEY, OP_REC: begin
              if (!pulse_q) begin
                saved_mode_d  = mode_q;
                saved_color_d = color_q;
                saved_speed_d = speed_q;
              end
              pulse_d           = 1'b1;
              prgb_d            = (opcode_i == OP_REC) ? RecRgb : in_rgb;
              pstart_d          = now_ms_i;
              paint_req_o.valid = 1'b1;
              paint_req_o.rgb   = (opcode_i == OP_REC) ? RecRgb : in_rgb;
            end
            default: ;
          endcase
        end
      end

      S_TICK: begin
        if (pulse_q) begin
          alu_req_o = '{op: ALU_SUB, a: now_q, b: pstart_q};
          state_d   = S_EL;
        end else if (mode_q == MODE_FLOW) begin
          alu_req_o = '{op: ALU_MUL, a: 32'(speed_q), b: 32'(Div3Mult)};
          state_d   = S_THR;
        end else if (mode_q == MODE_BREATH || mode_q == MODE_BLINK) begin
          alu_req_o = '{op: ALU_SUB, a: now_q, b: last_q};
          state_d   = S_DT;
        end else begin
          state_d = S_IDLE;
        end
      end

      // speed / 3 ready
      S_THR: begin
        thr_d     = alu_res_i[32:17];
        alu_req_o = '{op: ALU_SUB, a: now_q, b: last_q};
        state_d   = S_DT;
      end

      // elapsed since last step ready; compare against the interval
      S_DT: begin
        alu_req_o = '{op: ALU_SUB, a: alu_res_i[31:0], b: step_thr};
        state_d   = S_CMP;
      end

      S_CMP: begin
        state_d = S_IDLE;
        if (!alu_res_i[32]) begin
          last_d = now_q;
          unique case (mode_q)
            MODE_BREATH: begin
              level_d   = lvl_next;
              rising_d  = rise_next;
              alu_req_o = '{op: ALU_MUL, a: 32'(lvl_next), b: 32'(lvl_next)};
              state_d   = S_GAM;
            end
            MODE_FLOW: begin
              paint_req_o.valid   = 1'b1;
              paint_req_o.rgb     = color_q;
              paint_req_o.lit_all = 1'b0;
              paint_req_o.lit_idx = phase_q;
              phase_d             = ph_flow;
            end
            default: begin
              // blink
              phase_d           = (phase_q != '0) ? '0 : IdxW'(1);
              paint_req_o.valid = 1'b1;
              paint_req_o.rgb   = (phase_q != '0) ? 24'd0 : color_q;
            end
          endcase
        end
      end

      // gamma value, then scale each component
      S_GAM: begin
        gam_d     = div255(alu_res_i[15:0]);
        alu_req_o = '{op: ALU_MUL, a: 32'(color_q[23:16]),
                      b: 32'(div255(alu_res_i[15:0]))};
        state_d   = S_SR;
      end
      S_SR: begin
        sr_d      = div255(alu_res_i[15:0]);
        alu_req_o = '{op: ALU_MUL, a: 32'(color_q[15:8]), b: 32'(gam_q)};
        state_d   = S_SG;
      end
      S_SG: begin
        sg_d      = div255(alu_res_i[15:0]);
        alu_req_o = '{op: ALU_MUL, a: 32'(color_q[7:0]), b: 32'(gam_q)};
        state_d   = S_SB;
      end
      S_SB: begin
        paint_req_o.valid = 1'b1;
        paint_req_o.rgb   = {sr_q, sg_q, div255(alu_res_i[15:0])};
        state_d           = S_IDLE;
      end

      // pulse phases, thresholds checked in order
      S_EL: begin
        el_d      = alu_res_i[31:0];
        alu_req_o = '{op: ALU_SUB, a: alu_res_i[31:0], b: 32'(first_q)};
        state_d   = S_P0;
      end
      S_P0: begin
        if (alu_res_i[32]) begin
          paint_req_o.valid = 1'b1;
          paint_req_o.rgb   = prgb_q;
          state_d           = S_IDLE;
        end else begin
          alu_req_o = '{op: ALU_SUB, a: el_q, b: 32'(dark_q)};
          state_d   = S_P1;
        end
      end
      S_P1: begin
        if (alu_res_i[32]) begin
          paint_req_o.valid = 1'b1;
          state_d           = S_IDLE;
        end else begin
          alu_req_o = '{op: ALU_SUB, a: el_q, b: 32'(total_q)};
          state_d   = S_P2;
        end
      end
      S_P2: begin
        state_d = S_IDLE;
        if (alu_res_i[32]) begin
          paint_req_o.valid = 1'b1;
          paint_req_o.rgb   = prgb_q;
        end else begin
          // pulse over: restore saved effect
          pulse_d = 1'b0;
          mode_d  = saved_mode_q;
          color_d = saved_color_q;
          speed_d = saved_speed_q;
          if (saved_mode_q == MODE_SOLID) begin
            paint_req_o.valid = 1'b1;
            paint_req_o.rgb   = saved_color_q;
          end else if (saved_mode_q == MODE_OFF) begin
            paint_req_o.valid = 1'b1;
          end
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      first_q       <= 16'd150;
      dark_q        <= 16'd300;
      total_q       <= 16'd500;
      min_step_q    <= 8'd4;
      mode_q        <= MODE_OFF;
      color_q       <= 24'd0;
      speed_q       <= 16'd1000;
      saved_mode_q  <= MODE_OFF;
      saved_color_q <= 24'd0;
      saved_speed_q <= 16'd1000;
      last_q        <= 32'd0;
      pstart_q      <= 32'd0;
      phase_q       <= '0;
      level_q       <= 8'd0;
      rising_q      <= 1'b1;
      pulse_q       <= 1'b0;
      prgb_q        <= 24'd0;
    end else begin
      state_q       <= state_d;
      first_q       <= first_d;
      dark_q        <= dark_d;
      total_q       <= total_d;
      min_step_q    <= min_step_d;
      mode_q        <= mode_d;
      color_q       <= color_d;
      speed_q       <= speed_d;
      saved_mode_q  <= saved_mode_d;
      saved_color_q <= saved_color_d;
      saved_speed_q <= saved_speed_d;
      last_q        <= last_d;
      pstart_q      <= pstart_d;
      phase_q       <= phase_d;
      level_q       <= level_d;
      rising_q      <= rising_d;
      pulse_q       <= pulse_d;
      prgb_q        <= prgb_d;
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    now_q <= now_d;
    el_q  <= el_d;
    thr_q <= thr_d;
    gam_q <= gam_d;
    sr_q  <= sr_d;
    sg_q  <= sg_d;
  end

endmodule

### rtl/rgb_led_effect_engine.sv
// ----------------------------------------------------------------------------
// rgb_led_effect_engine: LED strip effect engine
// Takes timed events and emits per-pixel color items for each repaint.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_ready_o) takes one event item: opcode,
//   current time in ms, mode, color and speed. Output channel (out_valid_o /
//   out_ready_i) gives one item per pixel, pixel 0 first, with frame_last_o
//   on the last pixel. Config channel (cfg_valid_i / cfg_ready_o) writes the
//   pulse phase ends and the breathing minimum step; it is always ready.
// Sequencing:
//   One event at a time. A non-tick event is handled in the cycle it is
//   accepted; a tick runs its pulse or interval compares, and for breathing
//   the gamma scaling, on the one shared subtract/multiply unit. A repaint
//   then gives LedCount output items, and in_ready_o stays low until the last
//   pixel item is taken, so a stalled receiver holds off the next event.
// Reset:
//   Clears to mode off, speed 1000, no pulse, and the default config values.
// ----------------------------------------------------------------------------
module rgb_led_effect_engine (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [2:0]                opcode_i,
  input  logic [31:0]               now_ms_i,
  input  logic [2:0]                mode_in_i,
  input  logic [7:0]                red_in_i,
  input  logic [7:0]                green_in_i,
  input  logic [7:0]                blue_in_i,
  input  logic [15:0]               speed_ms_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [rle_pkg::IdxW-1:0]  pixel_index_o,
  output logic [7:0]                red_out_o,
  output logic [7:0]                green_out_o,
  output logic [7:0]                blue_out_o,
  output logic                      frame_last_o,
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [7:0]                cfg_index_i,
  input  logic [15:0]               cfg_data_i
);
  import rle_pkg::*;

  alu_req_t    alu_req;
  logic [32:0] alu_res;
  paint_req_t  paint_req;
  logic        paint_busy;

  assign cfg_ready_o = 1'b1;

  // sequencer and effect state
  rle_ctl u_ctl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .opcode_i     (opcode_i),
    .now_ms_i     (now_ms_i),
    .mode_in_i    (mode_in_i),
    .red_in_i     (red_in_i),
    .green_in_i   (green_in_i),
    .blue_in_i    (blue_in_i),
    .speed_ms_i   (speed_ms_i),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .alu_req_o    (alu_req),
    .alu_res_i    (alu_res),
    .paint_req_o  (paint_req),
    .paint_busy_i (paint_busy)
  );

  // shared subtract / multiply unit
  rle_alu u_alu (
    .clk_i (clk_i),
    .req_i (alu_req),
    .res_o (alu_res)
  );

  // pixel output sequencer
  rle_painter u_painter (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .req_i         (paint_req),
    .busy_o        (paint_busy),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .pixel_index_o (pixel_index_o),
    .red_out_o     (red_out_o),
    .green_out_o   (green_out_o),
    .blue_out_o    (blue_out_o),
    .frame_last_o  (frame_last_o)
  );

endmodule

### verif/rle_frame_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rle_frame_checker: pixel stream checker for the RGB LED effect engine
// Watches the event, config and pixel channels, keeps its own copy of the
// effect state, predicts the pixel items of every event and compares them in
// order with what the engine emits.
// ----------------------------------------------------------------------------
module rle_frame_checker (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  input  logic                     in_ready_i,
  input  logic [2:0]               opcode_i,
  input  logic [31:0]              now_ms_i,
  input  logic [2:0]               mode_in_i,
  input  logic [7:0]               red_in_i,
  input  logic [7:0]               green_in_i,
  input  logic [7:0]               blue_in_i,
  input  logic [15:0]              speed_ms_i,
  input  logic                     out_valid_i,
  input  logic                     out_ready_i,
  input  logic [rle_pkg::IdxW-1:0] pixel_index_i,
  input  logic [7:0]               red_out_i,
  input  logic [7:0]               green_out_i,
  input  logic [7:0]               blue_out_i,
  input  logic                     frame_last_i,
  input  logic                     cfg_valid_i,
  input  logic                     cfg_ready_i,
  input  logic [7:0]               cfg_index_i,
  input  logic [15:0]              cfg_data_i,
  output int unsigned              err_cnt_o,
  output int unsigned              pending_o
);
  import rle_pkg::*;

  localparam int unsigned MaxReports = 40;

  typedef struct packed {
    logic [IdxW-1:0] idx;
    logic [7:0]      red;
    logic [7:0]      green;
    logic [7:0]      blue;
    logic            last;
  } pixel_t;

  // pixel items still owed by the engine, oldest first
  pixel_t pixel_q[$];

  // config copy
  logic [15:0] first_on_ms, dark_end_ms, total_end_ms;
  logic [7:0]  min_step_ms;

  // effect state copy
  logic [2:0]  cur_mode, save_mode;
  logic [23:0] cur_rgb, save_rgb, flash_rgb;
  logic [15:0] cur_speed, save_speed;
  logic [31:0] step_stamp, flash_start;
  logic [7:0]  phase, level;
  logic        rising, flashing;

  int unsigned errs = 0;

  task automatic reset_model();
    first_on_ms  = 16'd150;
    dark_end_ms  = 16'd300;
    total_end_ms = 16'd500;
    min_step_ms  = 8'd4;
    cur_mode     = MODE_OFF;
    cur_rgb      = '0;
    cur_speed    = 16'd1000;
    step_stamp   = '0;
    phase        = '0;
    level        = '0;
    rising       = 1'b1;
    flashing     = 1'b0;
    flash_rgb    = '0;
    flash_start  = '0;
    save_mode    = MODE_OFF;
    save_rgb     = '0;
    save_speed   = 16'd1000;
  endtask

  // one repaint: all pixels in rgb, or only pixel lit_idx when one_hot is set
  task automatic queue_frame(input logic [23:0] rgb, input logic one_hot,
                             input logic [7:0] lit_idx);
    pixel_t px;
    logic   lit;
    for (int k = 0; k < LedCount; k++) begin
      lit      = !one_hot || (k == int'(lit_idx));
      px.idx   = IdxW'(k);
      px.red   = lit ? rgb[23:16] : 8'd0;
      px.green = lit ? rgb[15:8] : 8'd0;
      px.blue  = lit ? rgb[7:0] : 8'd0;
      px.last  = (k == LedCount - 1);
      pixel_q.push_back(px);
    end
  endtask

  task automatic predict_tick(input logic [31:0] now);
    logic [31:0] since_step, since_flash, interval;
    int unsigned gamma;
    logic [23:0] dim;
    since_step  = now - step_stamp;
    since_flash = now - flash_start;
    if (flashing) begin
      // lit, dark, lit again, then back to the saved effect
      if (since_flash < 32'(first_on_ms)) begin
        queue_frame(flash_rgb, 1'b0, 8'd0);
      end else if (since_flash < 32'(dark_end_ms)) begin
        queue_frame(24'd0, 1'b0, 8'd0);
      end else if (since_flash < 32'(total_end_ms)) begin
        queue_frame(flash_rgb, 1'b0, 8'd0);
      end else begin
        flashing  = 1'b0;
        cur_mode  = save_mode;
        cur_rgb   = save_rgb;
        cur_speed = save_speed;
        if (cur_mode == MODE_SOLID) queue_frame(cur_rgb, 1'b0, 8'd0);
        else if (cur_mode == MODE_OFF) queue_frame(24'd0, 1'b0, 8'd0);
      end
    end else begin
      case (cur_mode)
        MODE_BREATH: begin
          interval = 32'(cur_speed / 16'd512);
          if (interval < 32'(min_step_ms)) interval = 32'(min_step_ms);
          if (since_step >= interval) begin
            step_stamp = now;
            if (rising) begin
              level = level + 8'd2;
              if (level >= 8'd254) begin
                level  = 8'd255;
                rising = 1'b0;
              end
            end else if (level <= 8'd2) begin
              level  = 8'd0;
              rising = 1'b1;
            end else begin
              level = level - 8'd2;
            end
            // squared gamma, both divisions truncate
            gamma = 32'(level) * 32'(level) / 255;
            dim = {8'(32'(cur_rgb[23:16]) * gamma / 255),
                   8'(32'(cur_rgb[15:8]) * gamma / 255),
                   8'(32'(cur_rgb[7:0]) * gamma / 255)};
            queue_frame(dim, 1'b0, 8'd0);
          end
        end
        MODE_FLOW: begin
          if (since_step >= 32'(cur_speed / 16'd3)) begin
            step_stamp = now;
            queue_frame(cur_rgb, 1'b1, phase);
            phase = 8'((32'(phase) + 1) % LedCount);
          end
        end
        MODE_BLINK: begin
          if (since_step >= 32'(cur_speed / 16'd2)) begin
            step_stamp = now;
            phase = (phase != 8'd0) ? 8'd0 : 8'd1;
            queue_frame((phase != 8'd0) ? cur_rgb : 24'd0, 1'b0, 8'd0);
          end
        end
        default: ;
      endcase
    end
  endtask

  task automatic predict_event(input logic [2:0] op, input logic [31:0] now,
                               input logic [2:0] md, input logic [23:0] rgb,
                               input logic [15:0] spd);
    case (op)
      OP_TICK: predict_tick(now);
      OP_MODE: begin
        cur_mode   = md;
        cur_rgb    = rgb;
        cur_speed  = spd;
        phase      = '0;
        level      = '0;
        rising     = 1'b1;
        step_stamp = now;
        flashing   = 1'b0;
        if (md == MODE_OFF) queue_frame(24'd0, 1'b0, 8'd0);
        else if (md == MODE_SOLID) queue_frame(rgb, 1'b0, 8'd0);
      end
      OP_SOLID: begin
        cur_mode = MODE_SOLID;
        cur_rgb  = rgb;
        flashing = 1'b0;
        queue_frame(rgb, 1'b0, 8'd0);
      end
      OP_OFF: begin
        cur_mode = MODE_OFF;
        flashing = 1'b0;
        queue_frame(24'd0, 1'b0, 8'd0);
      end
      OP_KEY, OP_REC: begin
        // a pulse on top of a pulse keeps the first saved effect
        if (!flashing) begin
          save_mode  = cur_mode;
          save_rgb   = cur_rgb;
          save_speed = cur_speed;
        end
        flashing    = 1'b1;
        flash_rgb   = (op == OP_REC) ? RecRgb : rgb;
        flash_start = now;
        queue_frame(flash_rgb, 1'b0, 8'd0);
      end
      default: ;
    endcase
  endtask

  task automatic note_field(input string name, input int unsigned want,
                            input int unsigned got);
    if (want != got) begin
      if (errs < MaxReports)
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      errs++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : monitor
    pixel_t want;
    if (!rst_ni) begin
      reset_model();
      pixel_q.delete();
      errs = 0;
      err_cnt_o <= 0;
      pending_o <= 0;
    end else begin
      // compare the pixel item taken at this edge
      if (out_valid_i && out_ready_i) begin
        if (pixel_q.size() == 0) begin
          if (errs < MaxReports)
            $display("%0t: pixel item with none expected, expected nothing, got %0d %h%h%h %b",
                     $time, pixel_index_i, red_out_i, green_out_i, blue_out_i,
                     frame_last_i);
          errs++;
        end else begin
          want = pixel_q.pop_front();
          note_field("pixel_index", want.idx, pixel_index_i);
          note_field("red_out", want.red, red_out_i);
          note_field("green_out", want.green, green_out_i);
          note_field("blue_out", want.blue, blue_out_i);
          note_field("frame_last", want.last, frame_last_i);
        end
      end
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          REG_FIRST_ON: first_on_ms  = cfg_data_i;
          REG_DARK:     dark_end_ms  = cfg_data_i;
          REG_TOTAL:    total_end_ms = cfg_data_i;
          REG_MIN_STEP: min_step_ms  = cfg_data_i[7:0];
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i)
        predict_event(opcode_i, now_ms_i, mode_in_i,
                      {red_in_i, green_in_i, blue_in_i}, speed_ms_i);
      err_cnt_o <= errs;
      pending_o <= pixel_q.size();
    end
  end

endmodule

### verif/rgb_led_effect_engine_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rgb_led_effect_engine_tb: testbench for the RGB LED effect engine
// Drives directed and random event items with random gaps on the event side
// and random stalls on the pixel side, steps through several pulse and
// breathing configs, and lets rle_frame_checker predict and compare.
// ----------------------------------------------------------------------------
module rgb_led_effect_engine_tb;
  import rle_pkg::*;

  // codes with no package name
  localparam logic [2:0] OP_RSVD_A   = 3'd6;
  localparam logic [2:0] OP_RSVD_B   = 3'd7;
  localparam logic [2:0] MODE_IDLE   = 3'd5;
  localparam logic [2:0] MODE_RSVD_A = 3'd6;
  localparam logic [2:0] MODE_RSVD_B = 3'd7;

  localparam int unsigned DrainCycles = 16;
  localparam int unsigned CycleLimit  = 600000;

  logic            clk_i;
  logic            rst_ni;
  logic            in_valid_i;
  logic            in_ready_o;
  logic [2:0]      opcode_i;
  logic [31:0]     now_ms_i;
  logic [2:0]      mode_in_i;
  logic [7:0]      red_in_i;
  logic [7:0]      green_in_i;
  logic [7:0]      blue_in_i;
  logic [15:0]     speed_ms_i;
  logic            out_valid_o;
  logic            out_ready_i;
  logic [IdxW-1:0] pixel_index_o;
  logic [7:0]      red_out_o;
  logic [7:0]      green_out_o;
  logic [7:0]      blue_out_o;
  logic            frame_last_o;
  logic            cfg_valid_i;
  logic            cfg_ready_o;
  logic [7:0]      cfg_index_i;
  logic [15:0]     cfg_data_i;

  int unsigned err_cnt;
  int unsigned pend_cnt;
  int unsigned cycle_cnt = 0;
  int unsigned items_sent = 0;

  // stimulus-side view of time and config
  logic [31:0] ms_now;
  logic [15:0] first_now, dark_now, total_now;
  logic [7:0]  min_step_now;
  bit          idling_on = 1'b1;

  rgb_led_effect_engine u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .opcode_i      (opcode_i),
    .now_ms_i      (now_ms_i),
    .mode_in_i     (mode_in_i),
    .red_in_i      (red_in_i),
    .green_in_i    (green_in_i),
    .blue_in_i     (blue_in_i),
    .speed_ms_i    (speed_ms_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .pixel_index_o (pixel_index_o),
    .red_out_o     (red_out_o),
    .green_out_o   (green_out_o),
    .blue_out_o    (blue_out_o),
    .frame_last_o  (frame_last_o),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  rle_frame_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_i    (in_ready_o),
    .opcode_i      (opcode_i),
    .now_ms_i      (now_ms_i),
    .mode_in_i     (mode_in_i),
    .red_in_i      (red_in_i),
    .green_in_i    (green_in_i),
    .blue_in_i     (blue_in_i),
    .speed_ms_i    (speed_ms_i),
    .out_valid_i   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .pixel_index_i (pixel_index_o),
    .red_out_i     (red_out_o),
    .green_out_i   (green_out_o),
    .blue_out_i    (blue_out_o),
    .frame_last_i  (frame_last_o),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_i   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .err_cnt_o     (err_cnt),
    .pending_o     (pend_cnt)
  );

  // 2 ns clock
  always begin
    clk_i = 1'b0;
    #1;
    clk_i = 1'b1;
    #1;
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CycleLimit) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // mostly short gaps, a few long ones
  function automatic int unsigned gap_len(input bit may_skip);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (may_skip && r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [23:0] rand_rgb();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r == 0) return 24'h000000;
    if (r == 1) return 24'hFFFFFF;
    return 24'($urandom);
  endfunction

  function automatic logic [15:0] rand_speed();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 5) return 16'h0000;
    if (r < 10) return 16'hFFFF;
    if (r < 60) return 16'($urandom_range(0, 600));
    if (r < 90) return 16'($urandom_range(600, 3000));
    return 16'($urandom);
  endfunction

  // pixel side: ready in bursts with random stalls between them
  initial begin : pixel_sink
    int unsigned hold;
    logic        rdy;
    hold        = 0;
    rdy         = 1'b1;
    out_ready_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (!idling_on) begin
        rdy  = 1'b1;
        hold = 0;
      end else if (hold != 0) begin
        hold--;
      end else begin
        rdy  = !rdy;
        hold = rdy ? (($urandom_range(0, 9) == 0) ? 80 : $urandom_range(0, 30))
                   : gap_len(1'b0) - 1;
      end
      out_ready_i <= rdy;
    end
  end

  // one event item at time ms_now
  task automatic send_event(input logic [2:0] op, input logic [2:0] md,
                            input logic [23:0] rgb, input logic [15:0] spd);
    int unsigned gap;
    gap = idling_on ? gap_len(1'b1) : 0;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    opcode_i   <= op;
    now_ms_i   <= ms_now;
    mode_in_i  <= md;
    red_in_i   <= rgb[23:16];
    green_in_i <= rgb[15:8];
    blue_in_i  <= rgb[7:0];
    speed_ms_i <= spd;
    do @(posedge clk_i); while (!in_ready_o);
    if (op <= OP_REC) items_sent++;
  endtask

  // tick after dt_ms; unused fields carry random bits
  task automatic tick_after(input int unsigned dt_ms);
    ms_now = ms_now + dt_ms;
    send_event(OP_TICK, 3'($urandom), 24'($urandom), 16'($urandom));
  endtask

  // wait for every owed pixel, then for a tick that may still be in flight
  task automatic settle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pend_cnt != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [7:0] idx, input logic [15:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
  endtask

  task automatic load_config(input logic [15:0] first_on, input logic [15:0] dark_end,
                             input logic [15:0] total_end, input logic [7:0] min_step);
    write_reg(REG_FIRST_ON, first_on);
    write_reg(REG_DARK, dark_end);
    write_reg(REG_TOTAL, total_end);
    // upper bits of the step register are dropped
    write_reg(REG_MIN_STEP, {8'($urandom), min_step});
    // an index past the map must change nothing
    write_reg(8'($urandom_range(int'(REG_MIN_STEP) + 1, 255)), 16'($urandom));
    cfg_valid_i  <= 1'b0;
    first_now    = first_on;
    dark_now     = dark_end;
    total_now    = total_end;
    min_step_now = min_step;
  endtask

  // pulse with ticks around and across its phase ends, now and then cut short
  task automatic pulse_burst();
    logic [31:0] t0;
    logic [2:0]  op;
    int unsigned r;
    if ($urandom_range(0, 1) == 1) send_event(OP_MODE, 3'($urandom), rand_rgb(), rand_speed());
    op = ($urandom_range(0, 1) == 1) ? OP_KEY : OP_REC;
    t0 = ms_now;
    send_event(op, 3'($urandom), rand_rgb(), rand_speed());
    repeat ($urandom_range(2, 8)) begin
      r = $urandom_range(0, 99);
      if (r < 20) begin
        // land on a phase end or just short of it
        case ($urandom_range(0, 2))
          0: ms_now = t0 + 32'(first_now);
          1: ms_now = t0 + 32'(dark_now);
          default: ms_now = t0 + 32'(total_now);
        endcase
        ms_now = ms_now - $urandom_range(0, 1);
        send_event(OP_TICK, 3'($urandom), 24'($urandom), 16'($urandom));
      end else if (r < 82) begin
        tick_after($urandom_range(0, 200));
      end else if (r < 92) begin
        ms_now = ms_now + $urandom_range(0, 50);
        t0 = ms_now;
        send_event(($urandom_range(0, 1) == 1) ? OP_KEY : OP_REC, 3'($urandom),
                   rand_rgb(), rand_speed());
      end else begin
        case ($urandom_range(0, 2))
          0: send_event(OP_SOLID, 3'($urandom), rand_rgb(), rand_speed());
          1: send_event(OP_OFF, 3'($urandom), rand_rgb(), rand_speed());
          default: send_event(OP_MODE, 3'($urandom), rand_rgb(), rand_speed());
        endcase
      end
    end
  endtask

  // animated effect followed by ticks spaced around its step interval
  task automatic anim_run(input logic [2:0] md, input logic [15:0] spd,
                          input int unsigned ticks, input bit sure_step);
    int unsigned step_ms;
    send_event(OP_MODE, md, rand_rgb(), spd);
    if (md == MODE_FLOW) step_ms = spd / 16'd3;
    else if (md == MODE_BLINK) step_ms = spd / 16'd2;
    else step_ms = (spd / 16'd512 > min_step_now) ? spd / 16'd512 : min_step_now;
    repeat (ticks) begin
      if (sure_step || $urandom_range(0, 3) != 0)
        tick_after(step_ms + $urandom_range(0, 2));
      else
        tick_after($urandom_range(0, step_ms));
    end
  endtask

  task automatic run_phase(input int unsigned target);
    int unsigned start, r;
    logic [2:0]  md;
    start = items_sent;
    while (items_sent - start < target) begin
      r = $urandom_range(0, 99);
      if (r < 45) begin
        pulse_burst();
      end else if (r < 85) begin
        r = $urandom_range(0, 99);
        md = (r < 35) ? MODE_BREATH : (r < 65) ? MODE_FLOW :
             (r < 90) ? MODE_BLINK : 3'($urandom);
        anim_run(md, rand_speed(), $urandom_range(2, 10), 1'b0);
      end else begin
        // noise: any opcode, any field, time jumps anywhere
        ms_now = $urandom;
        send_event(3'($urandom), 3'($urandom), 24'($urandom), 16'($urandom));
      end
    end
  endtask

  initial begin : stimulus
    logic [15:0] cut;
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    opcode_i     = OP_TICK;
    now_ms_i     = '0;
    mode_in_i    = MODE_OFF;
    red_in_i     = '0;
    green_in_i   = '0;
    blue_in_i    = '0;
    speed_ms_i   = '0;
    cfg_valid_i  = 1'b0;
    cfg_index_i  = REG_FIRST_ON;
    cfg_data_i   = '0;
    first_now    = 16'd150;
    dark_now     = 16'd300;
    total_now    = 16'd500;
    min_step_now = 8'd4;
    // start close to the 32-bit wrap
    ms_now       = 32'hFFFF_FF00;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: off after reset, solid colors, pulse phases and restore
    send_event(OP_TICK, MODE_OFF, 24'h000000, 16'h0000);
    send_event(OP_MODE, MODE_SOLID, 24'hFFFFFF, 16'hFFFF);
    send_event(OP_SOLID, MODE_OFF, 24'h000000, 16'h0000);
    send_event(OP_SOLID, MODE_OFF, 24'h123456, 16'h0000);
    send_event(OP_KEY, MODE_OFF, 24'hFFFFFF, 16'h0000);
    tick_after(149);
    tick_after(1);
    tick_after(150);
    tick_after(199);
    tick_after(1);
    send_event(OP_OFF, MODE_SOLID, 24'hFFFFFF, 16'hFFFF);
    // a key pulse on top of a recording pulse keeps the saved off mode
    send_event(OP_REC, MODE_OFF, 24'hABCDEF, 16'h0000);
    ms_now = ms_now + 10;
    send_event(OP_KEY, MODE_OFF, 24'h00FF00, 16'h0000);
    tick_after(500);
    // flow across the whole strip and its wrap, blink on and off
    send_event(OP_MODE, MODE_FLOW, 24'hAABBCC, 16'd3);
    tick_after(0);
    repeat (4) tick_after(1);
    send_event(OP_MODE, MODE_BLINK, 24'hFF00FF, 16'd4);
    tick_after(1);
    tick_after(2);
    tick_after(2);
    // breathing at the slowest speed
    send_event(OP_MODE, MODE_BREATH, 24'hFFFFFF, 16'hFFFF);
    tick_after(127);
    tick_after(126);
    // modes and opcodes that paint nothing
    send_event(OP_MODE, MODE_IDLE, 24'h808080, 16'd1);
    tick_after(1000);
    send_event(OP_RSVD_A, MODE_SOLID, 24'hFFFFFF, 16'hFFFF);
    send_event(OP_RSVD_B, MODE_SOLID, 24'hFFFFFF, 16'hFFFF);
    send_event(OP_MODE, MODE_RSVD_B, 24'hFFFFFF, 16'd0);
    tick_after(5);
    send_event(OP_MODE, MODE_RSVD_A, 24'hFFFFFF, 16'd0);
    tick_after(5);

    // a full rise to the top of the breathing ramp and part of the fall
    anim_run(MODE_BREATH, 16'($urandom_range(0, 2047)), 128, 1'b1);
    run_phase(3);

    // all phase ends at zero, no idling on either side
    settle();
    load_config(16'd0, 16'd0, 16'd0, 8'd0);
    idling_on = 1'b0;
    run_phase(3);

    // all at maximum
    settle();
    idling_on = 1'b1;
    load_config(16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF);
    run_phase(3);

    // phase ends out of order
    settle();
    cut = 16'($urandom_range(100, 400));
    load_config(cut, 16'($urandom_range(0, cut)), 16'($urandom_range(0, 600)),
                8'($urandom));
    run_phase(3);

    // short increasing phases, fast breathing
    settle();
    cut = 16'($urandom_range(20, 120));
    load_config(cut, cut + 16'($urandom_range(0, 100)), cut + 16'($urandom_range(100, 250)),
                8'($urandom_range(1, 8)));
    run_phase(3);

    settle();
    if (err_cnt == 0 && pend_cnt == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

### sim.f
rtl/rle_pkg.sv
rtl/rle_alu.sv
rtl/rle_painter.sv
rtl/rle_ctl.sv
rtl/rgb_led_effect_engine.sv
verif/rle_frame_checker.sv
verif/rgb_led_effect_engine_tb.sv
